>>> rtl/core/gf3s_pkg.sv
// Shared constants, item types and kernel weights for the 3x3 Gaussian filter stream unit.
// Used by every module in rtl/core but gf3s_ram; has no dependencies of its own.
package gf3s_pkg;

	localparam int PIX_W         = 8;
	localparam int LW_W          = 11;
	localparam int FH_W          = 13;
	localparam int CFG_DATA_W    = 13;
	localparam int ROW_W         = 13;
	localparam int HLAST_W       = 12;
	localparam int MAX_HEIGHT    = 4096;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int W_RESET       = 256;
	localparam int H_RESET       = 256;

	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = QPTR_W + 1;

	localparam int SUM_W      = 16;
	localparam int NORM_SHIFT = 7;
	localparam int ROUND_BIAS = 1 << 6;
	localparam int PIX_MAX    = 255;

	localparam logic [PIX_W-1:0] K_CORNER = 8'h08;
	localparam logic [PIX_W-1:0] K_EDGE   = 8'h10;
	localparam logic [PIX_W-1:0] K_CENTER = 8'h20;

	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	localparam logic REG_LINE_WIDTH   = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic             action;
		logic [PIX_W-1:0] pixel_in;
	} px_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             row_end;
		logic             frame_end;
	} res_item_t;

	typedef struct packed {
		logic top;
		logic bot;
		logic lft;
		logic rgt;
		logic row_end;
		logic frame_end;
	} geo_t;

	typedef struct packed {
		logic             valid;
		logic             emit;
		logic [PIX_W-1:0] pixel;
		geo_t             geo;
	} push_t;

	function automatic logic [PIX_W-1:0] kern_coef(input int r, input int k);
		logic [PIX_W-1:0] c;
		if (r == 1 && k == 1) begin
			c = K_CENTER;
		end else if (r == 1 || k == 1) begin
			c = K_EDGE;
		end else begin
			c = K_CORNER;
		end
		return c;
	endfunction

endpackage

>>> rtl/core/gf3s_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module gf3s_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/core/gf3s_ctrl.sv
// Position counters, configuration registers, drain bookkeeping and input flow control.
// Depends on gf3s_pkg; issues one line store push per cycle to gf3s_window while the output queue has room.
module gf3s_ctrl #(
	parameter int MAX_WIDTH = gf3s_pkg::MAX_WIDTH_DEF,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_index,
	input  logic [gf3s_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              px_valid,
	input  gf3s_pkg::px_item_t                px_item,
	output logic                              px_stall,
	input  logic                              res_pop,
	output gf3s_pkg::push_t                   push,
	output logic [COL_W-1:0]                  push_addr
);

	localparam int PEND_W    = $clog2(MAX_WIDTH + 2);
	localparam int MAXW_BITS = $clog2(MAX_WIDTH + 1);
	localparam int WCMP_W    = (gf3s_pkg::LW_W > MAXW_BITS) ? gf3s_pkg::LW_W : MAXW_BITS;
	localparam int RST_WIDTH = (gf3s_pkg::W_RESET > MAX_WIDTH) ? MAX_WIDTH : gf3s_pkg::W_RESET;

	logic [COL_W-1:0]                 w_last_q;
	logic [COL_W-1:0]                 in_col_q;
	logic [COL_W-1:0]                 out_col_q;
	logic [gf3s_pkg::HLAST_W-1:0]     h_last_q;
	logic [gf3s_pkg::ROW_W-1:0]       in_row_q;
	logic [gf3s_pkg::ROW_W-1:0]       out_row_q;
	logic [gf3s_pkg::ROW_W-1:0]       h_last_x;
	logic [PEND_W-1:0]                pend_q;
	logic [PEND_W-1:0]                pend_init;
	logic [gf3s_pkg::QCNT_W-1:0]      resv_q;
	logic                             is_drain;
	logic                             pend_nz;
	logic                             emit_now;
	logic                             room;
	logic                             silent;
	logic                             accept;
	logic                             do_push;
	logic                             res_take;
	logic                             last_px;
	logic                             in_wrap;
	logic                             out_wrap;
	logic [WCMP_W-1:0]                lw_x;
	logic [gf3s_pkg::FH_W-1:0]        fh;
	logic [COL_W-1:0]                 w_last_new;
	logic [gf3s_pkg::HLAST_W-1:0]     h_last_new;

	always_comb begin
		h_last_x = gf3s_pkg::ROW_W'(h_last_q);
		is_drain = px_item.action == gf3s_pkg::ACT_DRAIN;
		pend_nz  = pend_q != '0;
		emit_now = (in_row_q[gf3s_pkg::ROW_W-1:1] != '0) || (in_row_q[0] && in_col_q != '0);
		room     = resv_q < gf3s_pkg::QCNT_W'(gf3s_pkg::Q_DEPTH);
		// The first drain of a single-row frame needs an extra zero push with no result.
		silent   = px_valid && is_drain && pend_nz && !emit_now;
		px_stall = !room || (is_drain && pend_nz && !emit_now);
		accept   = px_valid && !px_stall;
		do_push  = silent || (accept && (is_drain == pend_nz));
		res_take = do_push && emit_now;
		in_wrap  = in_col_q == w_last_q;
		out_wrap = out_col_q == w_last_q;
		last_px  = !is_drain && in_wrap && (in_row_q == h_last_x);
		pend_init = PEND_W'(w_last_q) + PEND_W'(1) + PEND_W'(h_last_q != '0);

		push.valid         = do_push;
		push.emit          = emit_now;
		push.pixel         = is_drain ? '0 : px_item.pixel_in;
		push.geo.top       = out_row_q != '0;
		push.geo.bot       = out_row_q < h_last_x;
		push.geo.lft       = out_col_q != '0;
		push.geo.rgt       = !out_wrap;
		push.geo.row_end   = out_wrap;
		push.geo.frame_end = out_wrap && (out_row_q >= h_last_x);
		push_addr          = in_col_q;

		lw_x = WCMP_W'(cfg_data[gf3s_pkg::LW_W-1:0]);
		if (lw_x == '0) begin
			w_last_new = '0;
		end else if (lw_x > WCMP_W'(MAX_WIDTH)) begin
			w_last_new = COL_W'(MAX_WIDTH - 1);
		end else begin
			w_last_new = COL_W'(lw_x - WCMP_W'(1));
		end

		fh = cfg_data[gf3s_pkg::FH_W-1:0];
		if (fh == '0) begin
			h_last_new = '0;
		end else if (fh > gf3s_pkg::FH_W'(gf3s_pkg::MAX_HEIGHT)) begin
			h_last_new = gf3s_pkg::HLAST_W'(gf3s_pkg::MAX_HEIGHT - 1);
		end else begin
			h_last_new = gf3s_pkg::HLAST_W'(fh - gf3s_pkg::FH_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q  <= COL_W'(RST_WIDTH - 1);
			h_last_q  <= gf3s_pkg::HLAST_W'(gf3s_pkg::H_RESET - 1);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
			resv_q    <= '0;
		end else begin
			resv_q <= resv_q + gf3s_pkg::QCNT_W'(res_take) - gf3s_pkg::QCNT_W'(res_pop);
			if (cfg_valid) begin
				unique case (cfg_index)
					gf3s_pkg::REG_LINE_WIDTH:   w_last_q <= w_last_new;
					gf3s_pkg::REG_FRAME_HEIGHT: h_last_q <= h_last_new;
				endcase
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				pend_q    <= '0;
			end else begin
				if (do_push) begin
					if (in_wrap) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + gf3s_pkg::ROW_W'(1);
					end else begin
						in_col_q <= in_col_q + COL_W'(1);
					end
					if (emit_now) begin
						if (out_wrap) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + gf3s_pkg::ROW_W'(1);
						end else begin
							out_col_q <= out_col_q + COL_W'(1);
						end
					end
				end
				if (accept && !pend_nz && last_px) begin
					pend_q <= pend_init;
				end
				if (accept && is_drain && pend_nz) begin
					if (pend_q == PEND_W'(1)) begin
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
						pend_q    <= '0;
					end else begin
						pend_q <= pend_q - PEND_W'(1);
					end
				end
			end
		end
	end

endmodule

>>> rtl/core/gf3s_window.sv
// Line store read-modify-write with forwarding, the 3x3 window and the kernel sum.
// Depends on gf3s_pkg and gf3s_ram; takes pushes from gf3s_ctrl, feeds gf3s_outq.
module gf3s_window #(
	parameter int MAX_WIDTH = gf3s_pkg::MAX_WIDTH_DEF,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gf3s_pkg::push_t      push,
	input  logic [COL_W-1:0]     push_addr,
	output logic                 res_wr,
	output gf3s_pkg::res_item_t  res_data
);

	localparam int PW = gf3s_pkg::PIX_W;

	logic                       v_s1;
	logic                       emit_s1;
	logic                       fwd_s1;
	logic [COL_W-1:0]           addr_s1;
	logic [PW-1:0]              pix_s1;
	gf3s_pkg::geo_t             geo_s1;
	logic [2*PW-1:0]            fwd_data_s1;
	logic                       emit_s2;
	gf3s_pkg::geo_t             geo_s2;
	logic [2:0][2:0][PW-1:0]    win_q;
	logic [2*PW-1:0]            ram_rdata;
	logic [2*PW-1:0]            rd_sel;
	logic [2*PW-1:0]            wr_data;
	logic                       fwd_hit;
	logic [2:0]                 row_ok;
	logic [2:0]                 col_ok;
	logic [gf3s_pkg::SUM_W-1:0] sum;
	logic [gf3s_pkg::SUM_W-1:0] rnd;

	gf3s_ram #(
		.WIDTH(2 * PW),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk    (clk),
		.wr_en  (v_s1),
		.wr_addr(addr_s1),
		.wr_data(wr_data),
		.rd_en  (push.valid),
		.rd_addr(push_addr),
		.rd_data(ram_rdata)
	);

	always_comb begin
		rd_sel  = fwd_s1 ? fwd_data_s1 : ram_rdata;
		wr_data = {rd_sel[PW-1:0], pix_s1};
		fwd_hit = v_s1 && (addr_s1 == push_addr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
			emit_s2 <= 1'b0;
			win_q   <= '0;
		end else begin
			v_s1    <= push.valid;
			emit_s1 <= push.valid && push.emit;
			fwd_s1  <= push.valid && fwd_hit;
			emit_s2 <= emit_s1;
			if (v_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= rd_sel[2*PW-1:PW];
				win_q[1][2] <= rd_sel[PW-1:0];
				win_q[2][2] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			addr_s1 <= push_addr;
			pix_s1  <= push.pixel;
			geo_s1  <= push.geo;
		end
		fwd_data_s1 <= wr_data;
		geo_s2      <= geo_s1;
	end

	always_comb begin
		row_ok = {geo_s2.bot, 1'b1, geo_s2.top};
		col_ok = {geo_s2.rgt, 1'b1, geo_s2.lft};
		sum    = '0;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (row_ok[r] && col_ok[k]) begin
					sum = sum + gf3s_pkg::SUM_W'(win_q[r][k])
						* gf3s_pkg::SUM_W'(gf3s_pkg::kern_coef(r, k));
				end
			end
		end
		rnd = (sum + gf3s_pkg::SUM_W'(gf3s_pkg::ROUND_BIAS)) >> gf3s_pkg::NORM_SHIFT;
		if (rnd > gf3s_pkg::SUM_W'(gf3s_pkg::PIX_MAX)) begin
			res_data.pixel_out = PW'(gf3s_pkg::PIX_MAX);
		end else begin
			res_data.pixel_out = rnd[PW-1:0];
		end
		res_data.row_end   = geo_s2.row_end;
		res_data.frame_end = geo_s2.frame_end;
		res_wr             = emit_s2;
	end

endmodule

>>> rtl/core/gf3s_outq.sv
// Small output queue that holds finished result items until the sink takes them.
// Depends on gf3s_pkg.
module gf3s_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  gf3s_pkg::res_item_t  wdata,
	input  logic                 pop,
	output logic                 valid,
	output logic                 full,
	output gf3s_pkg::res_item_t  rdata
);

	gf3s_pkg::res_item_t          buf_q [gf3s_pkg::Q_DEPTH];
	logic [gf3s_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [gf3s_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [gf3s_pkg::QCNT_W-1:0]  cnt_q;

	always_comb begin
		valid = cnt_q != '0;
		full  = cnt_q == gf3s_pkg::QCNT_W'(gf3s_pkg::Q_DEPTH);
		rdata = buf_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + gf3s_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gf3s_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + gf3s_pkg::QCNT_W'(wr) - gf3s_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/core/gaussian_filter_3x3_stream_unit.sv
// Top level of the 3x3 Gaussian filter stream unit.
// Depends on gf3s_pkg, gf3s_ctrl, gf3s_window, gf3s_outq and gf3s_ram.
//
// Pixels enter in raster order at one item per clock while px_stall is low, and each result
// leaves one line plus one pixel behind its pixel, after the s1 and s2 registers. Both line
// stores sit in one RAM of MAX_WIDTH words of two pixels, read and written back once per push;
// a push that hits the word still being written takes the new value from a forwarding register,
// so equal addresses in consecutive cycles cost nothing. The input stalls while four results
// are held or in flight for the output queue. The first drain item of a single-row frame is
// held for one extra line store push before its first result. The RAM needs no clearing after
// reset. A configuration write restarts the frame and keeps the stored pixels.
module gaussian_filter_3x3_stream_unit #(
	parameter int MAX_WIDTH = gf3s_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [gf3s_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            px_valid,
	output logic                            px_stall,
	input  gf3s_pkg::px_item_t              px_item,
	output logic                            res_valid,
	input  logic                            res_stall,
	output gf3s_pkg::res_item_t             res_item
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	gf3s_pkg::push_t      push;
	logic [COL_W-1:0]     push_addr;
	logic                 res_wr;
	gf3s_pkg::res_item_t  res_data;
	logic                 res_pop;
	logic                 q_full;

	assign cfg_ready = 1'b1;
	assign res_pop   = res_valid && !res_stall;

	gf3s_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.px_valid (px_valid),
		.px_item  (px_item),
		.px_stall (px_stall),
		.res_pop  (res_pop),
		.push     (push),
		.push_addr(push_addr)
	);

	gf3s_window #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_addr(push_addr),
		.res_wr   (res_wr),
		.res_data (res_data)
	);

	gf3s_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_wr),
		.wdata (res_data),
		.pop   (res_pop),
		.valid (res_valid),
		.full  (q_full),
		.rdata (res_item)
	);

`ifndef SYNTH
	a_emit_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.emit |-> ##2 res_wr)
		else $error("A result-producing push did not reach the output queue.");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |-> !q_full || res_pop)
		else $error("Output queue written while full.");

	a_extra_push_silent: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !(px_valid && !px_stall) |-> !push.emit)
		else $error("A push without an accepted item produced a result.");
`endif

endmodule

>>> tb/gaussian_filter_3x3_stream_unit_test.sv
// Self-checking testbench for gaussian_filter_3x3_stream_unit: drives pixel and drain items,
// writes the size registers and checks every result against a predictor of the filter.
// Depends on gf3s_pkg and the RTL under rtl/core.
module gaussian_filter_3x3_stream_unit_test;
	import gf3s_pkg::*;

	localparam int MAX_W = MAX_WIDTH_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int SILENCE_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_LINE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic px_valid = 1'b0;
	logic px_stall;
	px_item_t px_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_item_t res_item;

	gaussian_filter_3x3_stream_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.px_valid(px_valid),
		.px_stall(px_stall),
		.px_item(px_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

	always #6 clk = ~clk;

	// Blur predictor state.
	logic [PIX_W-1:0] upper_line [MAX_W];
	logic [PIX_W-1:0] middle_line [MAX_W];
	logic [PIX_W-1:0] win [3][3];
	int unsigned col_in, row_in, out_col, out_row, drains_left;
	logic [LW_W-1:0] width_reg;
	logic [FH_W-1:0] height_reg;
	res_item_t expected_q [$];
	res_item_t oldest;

	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned items_sent = 0;
	int unsigned reg_writes = 0;
	int unsigned counted = 0;
	int unsigned silent_cycles = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	function automatic void restart_frame();
		col_in = 0;
		row_in = 0;
		out_col = 0;
		out_row = 0;
		drains_left = 0;
	endfunction

	function automatic void reset_blur_model();
		for (int i = 0; i < MAX_W; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				win[i][j] = '0;
			end
		end
		width_reg = LW_W'(W_RESET);
		height_reg = FH_W'(H_RESET);
		restart_frame();
	endfunction

	function automatic int unsigned cur_width();
		int unsigned w;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int unsigned cur_height();
		int unsigned h;
		h = height_reg;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		return h;
	endfunction

	function automatic bit shift_pixel(input logic [PIX_W-1:0] p, output res_item_t res);
		int unsigned w, h, c, co, ro, sum, coef;
		logic [PIX_W-1:0] u, m;
		bit emit, top, bot, lft, rgt, row_ok, col_ok;
		w = cur_width();
		h = cur_height();
		c = col_in % MAX_W;
		u = upper_line[c];
		m = middle_line[c];
		upper_line[c] = m;
		middle_line[c] = p;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = u;
		win[1][2] = m;
		win[2][2] = p;
		emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
		col_in++;
		if (col_in >= w) begin
			col_in = 0;
			if (row_in < 32'hFFFF) row_in++;
		end
		res = '0;
		if (!emit) return 1'b0;
		co = out_col;
		ro = out_row;
		top = ro > 0;
		bot = ro + 1 < h;
		lft = co > 0;
		rgt = co + 1 < w;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			row_ok = (i == 0) ? top : (i == 2) ? bot : 1'b1;
			for (int j = 0; j < 3; j++) begin
				col_ok = (j == 0) ? lft : (j == 2) ? rgt : 1'b1;
				coef = K_CORNER;
				if (i == 1) coef = coef << 1;
				if (j == 1) coef = coef << 1;
				if (row_ok && col_ok) sum += coef * win[i][j];
			end
		end
		sum = (sum + ROUND_BIAS) >> NORM_SHIFT;
		if (sum > PIX_MAX) sum = PIX_MAX;
		res.pixel_out = sum[PIX_W-1:0];
		res.row_end = (co + 1 >= w);
		res.frame_end = (co + 1 >= w) && (ro + 1 >= h);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			if (out_row < 32'hFFFF) out_row++;
		end
		return 1'b1;
	endfunction

	function automatic void predict_item(input px_item_t it);
		res_item_t res;
		bit got, last;
		int unsigned w, h, done;
		w = cur_width();
		h = cur_height();
		if (it.action == ACT_PUSH) begin
			if (drains_left != 0) return;
			last = (row_in + 1 == h) && (col_in + 1 == w);
			got = shift_pixel(it.pixel_in, res);
			if (last) begin
				done = out_row * w + out_col;
				drains_left = w * h - done;
			end
			if (got) expected_q.push_back(res);
		end else begin
			if (drains_left == 0) return;
			got = shift_pixel('0, res);
			if (!got) got = shift_pixel('0, res);
			if (!got) return;
			drains_left--;
			if (drains_left == 0) restart_frame();
			expected_q.push_back(res);
		end
	endfunction

	function automatic void predict_reg_write(input logic idx, input logic [CFG_DATA_W-1:0] data);
		if (idx == REG_LINE_WIDTH) begin
			width_reg = data[LW_W-1:0];
		end else begin
			height_reg = data[FH_W-1:0];
		end
		restart_frame();
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				predict_reg_write(cfg_index, cfg_data);
				reg_writes++;
			end
			if (px_valid && !px_stall) begin
				predict_item(px_item);
				items_sent++;
			end
			if (res_valid && !res_stall) begin
				results_checked++;
				if (expected_q.size() == 0) begin
					$error("result with no expectation: pixel_out %0d row_end %0b frame_end %0b",
						res_item.pixel_out, res_item.row_end, res_item.frame_end);
					mismatches++;
				end else begin
					oldest = expected_q.pop_front();
					if (res_item.pixel_out !== oldest.pixel_out) begin
						$error("pixel_out expected %0d actual %0d", oldest.pixel_out,
							res_item.pixel_out);
						mismatches++;
					end
					if (res_item.row_end !== oldest.row_end) begin
						$error("row_end expected %0b actual %0b", oldest.row_end, res_item.row_end);
						mismatches++;
					end
					if (res_item.frame_end !== oldest.frame_end) begin
						$error("frame_end expected %0b actual %0b", oldest.frame_end,
							res_item.frame_end);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((px_valid && !px_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
				silent_cycles <= 0;
			end else if (silent_cycles >= SILENCE_LIMIT) begin
				$display("no item moved for %0d cycles", silent_cycles);
				$display("gaussian_filter_3x3_stream_unit_test failed");
				$finish;
			end else begin
				silent_cycles <= silent_cycles + 1;
			end
		end
	end

	task automatic send_item(input logic act, input logic [PIX_W-1:0] pix);
		px_item_t it;
		it.action = act;
		it.pixel_in = pix;
		while ($urandom_range(99) < src_idle_pct) begin
			px_valid <= 1'b0;
			@(posedge clk);
		end
		px_valid <= 1'b1;
		px_item <= it;
		@(posedge clk);
		while (px_stall) @(posedge clk);
	endtask

	task automatic wait_idle();
		px_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int unsigned data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(data);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel == 0) return '0;
		if (sel == 1) return 8'hFF;
		return PIX_W'($urandom);
	endfunction

	// Sends one frame of random pixels and its drain items. Noise adds drains while nothing is
	// pending and pixels while drains are pending; a cut frame stops its drains early.
	task automatic push_frame(input int unsigned w, input int unsigned h, input int noise_pct,
			input bit cut);
		int unsigned drains;
		drains = (h == 1) ? w : w + 1;
		if (cut) drains = $urandom_range(drains - 1);
		for (int unsigned i = 0; i < w * h; i++) begin
			if ($urandom_range(99) < noise_pct) send_item(ACT_DRAIN, PIX_W'($urandom));
			send_item(ACT_PUSH, pick_pixel());
			counted++;
		end
		for (int unsigned d = 0; d < drains; d++) begin
			if ($urandom_range(99) < noise_pct) send_item(ACT_PUSH, pick_pixel());
			send_item(ACT_DRAIN, PIX_W'($urandom));
			counted++;
		end
		if ($urandom_range(99) < noise_pct) send_item(ACT_DRAIN, PIX_W'($urandom));
	endtask

	task automatic test_directed_cases();
		logic [PIX_W-1:0] pattern [9];
		src_idle_pct = 0;
		sink_stall_pct = 0;
		pattern = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01};
		write_reg(REG_LINE_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 3);
		send_item(ACT_DRAIN, 8'hFF);
		foreach (pattern[i]) send_item(ACT_PUSH, pattern[i]);
		send_item(ACT_PUSH, 8'h55);
		repeat (4) send_item(ACT_DRAIN, 8'hAA);
		send_item(ACT_DRAIN, 8'h00);
		write_reg(REG_LINE_WIDTH, 4);
		write_reg(REG_FRAME_HEIGHT, 1);
		send_item(ACT_PUSH, 8'h00);
		send_item(ACT_PUSH, 8'hFF);
		send_item(ACT_PUSH, 8'hFF);
		send_item(ACT_PUSH, 8'h7F);
		repeat (4) send_item(ACT_DRAIN, 8'hFF);
	endtask

	task automatic test_frame_abort();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_reg(REG_LINE_WIDTH, 6);
		write_reg(REG_FRAME_HEIGHT, 4);
		repeat (10) send_item(ACT_PUSH, pick_pixel());
		write_reg(REG_FRAME_HEIGHT, 3);
		push_frame(6, 3, 0, 1'b0);
		push_frame(6, 3, 0, 1'b1);
		write_reg(REG_LINE_WIDTH, 2);
		push_frame(2, 3, 0, 1'b0);
	endtask

	// Oversized and zero sizes are clamped; the largest sizes are entered and then cut short
	// by the next register write.
	task automatic test_register_extremes();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_reg(REG_LINE_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 2);
		push_frame(1, 2, 0, 1'b0);
		write_reg(REG_LINE_WIDTH, 13'h1FFF);
		write_reg(REG_FRAME_HEIGHT, 1);
		repeat (20) send_item(ACT_PUSH, pick_pixel());
		write_reg(REG_LINE_WIDTH, 5);
		write_reg(REG_FRAME_HEIGHT, 0);
		push_frame(5, 1, 0, 1'b0);
		write_reg(REG_LINE_WIDTH, 1);
		write_reg(REG_FRAME_HEIGHT, MAX_HEIGHT);
		repeat (24) send_item(ACT_PUSH, pick_pixel());
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		repeat (24) send_item(ACT_PUSH, pick_pixel());
		write_reg(REG_FRAME_HEIGHT, 1);
		push_frame(1, 1, 0, 1'b0);
	endtask

	task automatic test_random_frames(input int idle_pct, input int stall_pct,
			input int unsigned quota);
		int unsigned start, w, h, nframes;
		bit broken;
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		start = counted;
		while (counted - start < quota) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			h = $urandom_range(1, 5);
			write_reg(REG_LINE_WIDTH, w);
			write_reg(REG_FRAME_HEIGHT, h);
			nframes = $urandom_range(1, 3);
			broken = ($urandom_range(9) == 0);
			for (int unsigned f = 0; f < nframes; f++) begin
				push_frame(w, h, broken ? 8 : 2, broken && (f == nframes - 1));
			end
		end
	endtask

	initial begin
		reset_blur_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_frame_abort();
		test_register_extremes();
		test_random_frames(0, 0, 130);
		test_random_frames(81, 0, 130);
		test_random_frames(0, 81, 130);
		test_random_frames(36, 36, 130);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		wait_idle();
		$display("Sent %0d items and checked %0d results across %0d register writes,",
			items_sent, results_checked, reg_writes);
		$display("covering clamped sizes, aborted frames, dropped and ignored items.");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("gaussian_filter_3x3_stream_unit_test passed");
		end else begin
			$display("gaussian_filter_3x3_stream_unit_test failed");
		end
		$finish;
	end

endmodule
